// File: sv/bfa_pkg.sv
// Shared types and constants for the best-fit arena allocator.
`default_nettype none
package bfa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 32;
  localparam int ALIGN_BYTES  = 16;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int OFF_W  = 20;
  localparam int SZ_W   = 20;
  localparam int REQ_W  = 21;
  localparam int PTR_W  = 21;
  localparam int ARENA_W = 21;
  localparam int NEED_W = 22;

  localparam logic [ARENA_W-1:0] ARENA_MIN   = 21'd64;
  localparam logic [ARENA_W-1:0] ARENA_MAX   = 21'd1048576;
  localparam logic [ARENA_W-1:0] ARENA_RESET = 21'd65536;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESIZE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_PTR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_SHR   = 2'd2,
    OP_SHL   = 2'd3
  } cell_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SPLIT_SH,
    S_SPLIT_W0,
    S_SPLIT_W1,
    S_MARK,
    S_FREE_W,
    S_FREE_SH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [SZ_W-1:0]  size;
    logic             used;
  } seg_t;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    seg_t             seg;
  } cell_cmd_t;

  // Running results that ripple down the row during a scan.
  typedef struct packed {
    logic             bfound;
    logic [IDX_W-1:0] bidx;
    logic [SZ_W-1:0]  bsize;
    logic [OFF_W-1:0] boff;
    logic             mfound;
    logic [IDX_W-1:0] midx;
    logic [SZ_W-1:0]  msize;
    logic             nfree;
    logic [SZ_W-1:0]  nsize;
    logic             pfree;
    logic [SZ_W-1:0]  psize;
    logic [OFF_W-1:0] poff;
  } scan_t;

endpackage
`default_nettype wire

// File: sv/bfa_cell.sv
// One segment table entry with its slice of the best-fit and lookup scan.
`default_nettype none
module bfa_cell (
  input  wire                         clk_i,
  input  wire  [bfa_pkg::IDX_W-1:0]   pos_i,
  input  wire  bfa_pkg::cell_cmd_t    cmd_i,
  input  wire  bfa_pkg::seg_t         left_i,
  input  wire  bfa_pkg::seg_t         right_i,
  input  wire                         live_i,
  input  wire                         right_live_i,
  input  wire  [bfa_pkg::NEED_W-1:0]  need_i,
  input  wire  [bfa_pkg::PTR_W-1:0]   hdr_i,
  input  wire  bfa_pkg::scan_t        scan_i,
  output bfa_pkg::seg_t               seg_o,
  output bfa_pkg::scan_t              scan_o
);

  bfa_pkg::seg_t  seg_q, seg_d;
  bfa_pkg::scan_t scan_q, scan_d;
  logic           bcand, mhit;

  always_comb begin
    seg_d = seg_q;
    case (cmd_i.op)
      bfa_pkg::OP_WRITE: if (cmd_i.idx == pos_i) seg_d = cmd_i.seg;
      bfa_pkg::OP_SHR:   if (pos_i > cmd_i.idx) seg_d = left_i;
      bfa_pkg::OP_SHL:   if (pos_i >= cmd_i.idx) seg_d = right_i;
      default: ;
    endcase
  end

  // Strict less-than keeps the lowest address among equal sizes.
  assign bcand = live_i && !seg_q.used &&
                 ({2'b00, seg_q.size} >= need_i) &&
                 (!scan_i.bfound || (seg_q.size < scan_i.bsize));
  assign mhit  = live_i && seg_q.used && ({1'b0, seg_q.off} == hdr_i);

  always_comb begin
    scan_d = scan_i;
    if (bcand) begin
      scan_d.bfound = 1'b1;
      scan_d.bidx   = pos_i;
      scan_d.bsize  = seg_q.size;
      scan_d.boff   = seg_q.off;
    end
    if (mhit) begin
      scan_d.mfound = 1'b1;
      scan_d.midx   = pos_i;
      scan_d.msize  = seg_q.size;
      scan_d.nfree  = right_live_i && !right_i.used;
      scan_d.nsize  = right_i.size;
      scan_d.pfree  = (pos_i != '0) && !left_i.used;
      scan_d.psize  = left_i.size;
      scan_d.poff   = left_i.off;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    scan_q <= scan_d;
  end

  assign seg_o  = seg_q;
  assign scan_o = scan_q;

endmodule
`default_nettype wire

// File: sv/best_fit_arena_allocator.sv
// Top level: request sequencer driving a row of segment table cells.
//
//  channel | signals                          | direction
//  in      | in_valid_i / in_ready_o, 4 fields | request word in
//  out     | out_valid_o / out_ready_i, 4 flds | result word out
//  cfg     | cfg_valid_i / cfg_ready_o, data   | arena size write
//
// A word is accepted in the idle state, then the cell row is scanned while the running
// results ripple through all cells. The block then decides, updates the table and loads
// the result register before it takes the next word. A resize that relocates scans twice.
// Reset and every arena write rebuild the table in the init state, and a pending arena
// write goes ahead of a request word. A result that is not taken waits in the output
// register while the next word is processed; the block holds in its response state
// only while that register is still full.
`default_nettype none
module best_fit_arena_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [1:0]                   kind_i,
  input  wire  [bfa_pkg::REQ_W-1:0]    request_bytes_i,
  input  wire                          pointer_present_i,
  input  wire  [bfa_pkg::PTR_W-1:0]    pointer_offset_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         result_present_o,
  output logic [19:0]                  payload_offset_o,
  output logic [19:0]                  copy_bytes_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [bfa_pkg::ARENA_W-1:0]  cfg_data_i
);

  localparam int N = bfa_pkg::MAX_SEGMENTS;
  localparam int H = bfa_pkg::HEADER_BYTES;

  bfa_pkg::state_e              st_q, st_d;
  logic [bfa_pkg::IDX_W-1:0]    scnt_q, scnt_d;
  logic [bfa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [bfa_pkg::ARENA_W-1:0]  arena_q, arena_d, arena_eff;
  bfa_pkg::kind_e               kind_q, kind_d;
  logic                         pres_q, pres_d;
  logic [bfa_pkg::PTR_W-1:0]    ptr_q, ptr_d, hdr_q, hdr_d;
  logic [bfa_pkg::NEED_W-1:0]   need_q, need_d, need_in;
  logic                         reloc_q, reloc_d;
  bfa_pkg::status_e             stat_q, stat_d;
  logic                         has_q, has_d;
  logic [19:0]                  pay_q, pay_d, copy_q, copy_d;
  logic [bfa_pkg::IDX_W-1:0]    bidx_q, bidx_d;
  logic [bfa_pkg::SZ_W-1:0]     bsize_q, bsize_d;
  logic [bfa_pkg::OFF_W-1:0]    boff_q, boff_d;
  logic [bfa_pkg::IDX_W-1:0]    widx_q, widx_d, shidx_q, shidx_d;
  logic [bfa_pkg::OFF_W-1:0]    woff_q, woff_d;
  logic [bfa_pkg::SZ_W-1:0]     wsize_q, wsize_d;
  logic [1:0]                   nsh_q, nsh_d;
  logic                         ov_q, ov_d;
  bfa_pkg::status_e             ostat_q, ostat_d;
  logic                         ohas_q, ohas_d;
  logic [19:0]                  opay_q, opay_d, ocopy_q, ocopy_d;

  bfa_pkg::cell_cmd_t           cmd;
  bfa_pkg::seg_t                seg   [N];
  bfa_pkg::scan_t               scan  [N];
  logic [N-1:0]                 live;
  bfa_pkg::scan_t               c;
  logic                         range_ok, mok, reqz, do_alloc, do_free;
  logic [bfa_pkg::SZ_W-1:0]     msz;

  always_comb begin
    if (arena_q < bfa_pkg::ARENA_MIN)      arena_eff = bfa_pkg::ARENA_MIN;
    else if (arena_q > bfa_pkg::ARENA_MAX) arena_eff = bfa_pkg::ARENA_MAX;
    else                                   arena_eff = arena_q;
  end

  // Round up to the alignment by adding its mask and clearing the low bits.
  assign need_in = ({1'b0, request_bytes_i} + bfa_pkg::NEED_W'(bfa_pkg::ALIGN_BYTES - 1))
                   & ~bfa_pkg::NEED_W'(bfa_pkg::ALIGN_BYTES - 1);

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign live[k] = bfa_pkg::CNT_W'(k) < cnt_q;
    bfa_cell u_cell (
      .clk_i        (clk_i),
      .pos_i        (bfa_pkg::IDX_W'(k)),
      .cmd_i        (cmd),
      .left_i       ((k == 0) ? seg[0] : seg[(k == 0) ? 0 : k - 1]),
      .right_i      ((k == N - 1) ? seg[N-1] : seg[(k == N - 1) ? N - 1 : k + 1]),
      .live_i       (live[k]),
      .right_live_i ((k == N - 1) ? 1'b0 : live[(k == N - 1) ? N - 1 : k + 1]),
      .need_i       (need_q),
      .hdr_i        (hdr_q),
      .scan_i       ((k == 0) ? '0 : scan[(k == 0) ? 0 : k - 1]),
      .seg_o        (seg[k]),
      .scan_o       (scan[k])
    );
  end

  assign c        = scan[N-1];
  assign range_ok = (ptr_q >= bfa_pkg::PTR_W'(H)) && (hdr_q < arena_eff);
  assign mok      = c.mfound && range_ok;
  assign reqz     = (need_q == '0);
  assign do_alloc = (kind_q == bfa_pkg::KIND_ALLOC) ||
                    ((kind_q == bfa_pkg::KIND_RESIZE) && !pres_q && !reqz);
  assign do_free  = (kind_q == bfa_pkg::KIND_FREE) ||
                    ((kind_q == bfa_pkg::KIND_RESIZE) && reqz);
  assign msz      = c.nfree ? (c.msize + c.nsize + bfa_pkg::SZ_W'(H)) : c.msize;

  assign in_ready_o  = (st_q == bfa_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (st_q == bfa_pkg::S_IDLE);

  always_comb begin
    st_d = st_q; scnt_d = scnt_q; cnt_d = cnt_q; arena_d = arena_q;
    kind_d = kind_q; pres_d = pres_q; ptr_d = ptr_q; hdr_d = hdr_q; need_d = need_q;
    reloc_d = reloc_q; stat_d = stat_q; has_d = has_q; pay_d = pay_q; copy_d = copy_q;
    bidx_d = bidx_q; bsize_d = bsize_q; boff_d = boff_q;
    widx_d = widx_q; woff_d = woff_q; wsize_d = wsize_q; shidx_d = shidx_q; nsh_d = nsh_q;
    ov_d = ov_q; ostat_d = ostat_q; ohas_d = ohas_q; opay_d = opay_q; ocopy_d = ocopy_q;
    cmd = '{op: bfa_pkg::OP_NOP, idx: '0, seg: '0};

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (st_q)
      bfa_pkg::S_INIT: begin
        cmd.op  = bfa_pkg::OP_WRITE;
        cmd.idx = '0;
        cmd.seg = '{off: '0, size: bfa_pkg::SZ_W'(arena_eff - bfa_pkg::ARENA_W'(H)), used: 1'b0};
        cnt_d   = bfa_pkg::CNT_W'(1);
        st_d    = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        if (cfg_valid_i) begin
          arena_d = cfg_data_i;
          st_d    = bfa_pkg::S_INIT;
        end else if (in_valid_i) begin
          kind_d  = bfa_pkg::kind_e'(kind_i);
          pres_d  = pointer_present_i;
          ptr_d   = pointer_offset_i;
          hdr_d   = pointer_offset_i - bfa_pkg::PTR_W'(H);
          need_d  = need_in;
          reloc_d = 1'b0;
          stat_d  = bfa_pkg::ST_OK;
          has_d   = 1'b0;
          pay_d   = '0;
          copy_d  = '0;
          scnt_d  = '0;
          st_d    = bfa_pkg::S_SCAN;
        end
      end
      bfa_pkg::S_SCAN: begin
        scnt_d = scnt_q + bfa_pkg::IDX_W'(1);
        if (scnt_q == bfa_pkg::IDX_W'(N - 1)) st_d = bfa_pkg::S_DECIDE;
      end
      bfa_pkg::S_DECIDE: begin
        // Free path targets, used by plain free, zero-size resize and relocation.
        if (c.pfree) begin
          widx_d  = c.midx - bfa_pkg::IDX_W'(1);
          woff_d  = c.poff;
          wsize_d = c.psize + msz + bfa_pkg::SZ_W'(H);
          shidx_d = c.midx;
          nsh_d   = 2'd1 + {1'b0, c.nfree};
        end else begin
          widx_d  = c.midx;
          woff_d  = hdr_q[bfa_pkg::OFF_W-1:0];
          wsize_d = msz;
          shidx_d = c.midx + bfa_pkg::IDX_W'(1);
          nsh_d   = {1'b0, c.nfree};
        end
        bidx_d  = c.bidx;
        bsize_d = c.bsize;
        boff_d  = c.boff;
        st_d    = bfa_pkg::S_RESP;
        if (reloc_q) begin
          st_d = bfa_pkg::S_FREE_W;
        end else if (do_alloc || (kind_q == bfa_pkg::KIND_RESIZE && mok &&
                     !reqz && ({2'b00, c.msize} < need_q))) begin
          if (reqz || !c.bfound) begin
            stat_d = bfa_pkg::ST_NO_FIT;
          end else begin
            has_d = 1'b1;
            pay_d = c.boff + 20'(H);
            if (kind_q == bfa_pkg::KIND_RESIZE && pres_q) begin
              reloc_d = 1'b1;
              copy_d  = c.msize;
            end
            if (({3'b000, c.bsize} >= ({1'b0, need_q} + 23'(H + bfa_pkg::ALIGN_BYTES)))
                && (cnt_q < bfa_pkg::CNT_W'(N)))
              st_d = bfa_pkg::S_SPLIT_SH;
            else
              st_d = bfa_pkg::S_MARK;
          end
        end else if (do_free) begin
          if (!pres_q)
            stat_d = (kind_q == bfa_pkg::KIND_FREE) ? bfa_pkg::ST_OK : bfa_pkg::ST_NO_FIT;
          else if (!mok)
            stat_d = bfa_pkg::ST_BAD_PTR;
          else begin
            stat_d = (kind_q == bfa_pkg::KIND_FREE) ? bfa_pkg::ST_OK : bfa_pkg::ST_NO_FIT;
            st_d   = bfa_pkg::S_FREE_W;
          end
        end else if (kind_q == bfa_pkg::KIND_RESIZE) begin
          if (!mok) begin
            stat_d = bfa_pkg::ST_BAD_PTR;
          end else begin
            has_d = 1'b1;
            pay_d = ptr_q[19:0];
          end
        end
      end
      bfa_pkg::S_SPLIT_SH: begin
        cmd.op  = bfa_pkg::OP_SHR;
        cmd.idx = bidx_q;
        cnt_d   = cnt_q + bfa_pkg::CNT_W'(1);
        st_d    = bfa_pkg::S_SPLIT_W0;
      end
      bfa_pkg::S_SPLIT_W0: begin
        cmd.op  = bfa_pkg::OP_WRITE;
        cmd.idx = bidx_q;
        cmd.seg = '{off: boff_q, size: need_q[bfa_pkg::SZ_W-1:0], used: 1'b1};
        st_d    = bfa_pkg::S_SPLIT_W1;
      end
      bfa_pkg::S_SPLIT_W1: begin
        cmd.op  = bfa_pkg::OP_WRITE;
        cmd.idx = bidx_q + bfa_pkg::IDX_W'(1);
        cmd.seg = '{off: boff_q + 20'(H) + need_q[bfa_pkg::OFF_W-1:0],
                    size: bsize_q - need_q[bfa_pkg::SZ_W-1:0] - 20'(H), used: 1'b0};
        scnt_d  = '0;
        st_d    = reloc_q ? bfa_pkg::S_SCAN : bfa_pkg::S_RESP;
      end
      bfa_pkg::S_MARK: begin
        cmd.op  = bfa_pkg::OP_WRITE;
        cmd.idx = bidx_q;
        cmd.seg = '{off: boff_q, size: bsize_q, used: 1'b1};
        scnt_d  = '0;
        st_d    = reloc_q ? bfa_pkg::S_SCAN : bfa_pkg::S_RESP;
      end
      bfa_pkg::S_FREE_W: begin
        cmd.op  = bfa_pkg::OP_WRITE;
        cmd.idx = widx_q;
        cmd.seg = '{off: woff_q, size: wsize_q, used: 1'b0};
        cnt_d   = cnt_q - bfa_pkg::CNT_W'(nsh_q);
        st_d    = (nsh_q != 2'd0) ? bfa_pkg::S_FREE_SH : bfa_pkg::S_RESP;
      end
      bfa_pkg::S_FREE_SH: begin
        cmd.op  = bfa_pkg::OP_SHL;
        cmd.idx = shidx_q;
        nsh_d   = nsh_q - 2'd1;
        if (nsh_q == 2'd1) st_d = bfa_pkg::S_RESP;
      end
      bfa_pkg::S_RESP: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ostat_d = stat_q;
          ohas_d  = has_q;
          opay_d  = has_q ? pay_q : '0;
          ocopy_d = copy_q;
          st_d    = bfa_pkg::S_IDLE;
        end
      end
      default: st_d = bfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bfa_pkg::S_INIT;
      cnt_q   <= bfa_pkg::CNT_W'(1);
      arena_q <= bfa_pkg::ARENA_RESET;
      ov_q    <= 1'b0;
      reloc_q <= 1'b0;
      scnt_q  <= '0;
      nsh_q   <= '0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      arena_q <= arena_d;
      ov_q    <= ov_d;
      reloc_q <= reloc_d;
      scnt_q  <= scnt_d;
      nsh_q   <= nsh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;  pres_q  <= pres_d;  ptr_q   <= ptr_d;   hdr_q  <= hdr_d;
    need_q  <= need_d;  stat_q  <= stat_d;  has_q   <= has_d;   pay_q  <= pay_d;
    copy_q  <= copy_d;  bidx_q  <= bidx_d;  bsize_q <= bsize_d; boff_q <= boff_d;
    widx_q  <= widx_d;  woff_q  <= woff_d;  wsize_q <= wsize_d; shidx_q <= shidx_d;
    ostat_q <= ostat_d; ohas_q  <= ohas_d;  opay_q  <= opay_d;  ocopy_q <= ocopy_d;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = ostat_q;
  assign result_present_o = ohas_q;
  assign payload_offset_o = opay_q;
  assign copy_bytes_o     = ocopy_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= bfa_pkg::CNT_W'(1)) && (cnt_q <= bfa_pkg::CNT_W'(N)))
    else $error("segment count out of range");

  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == bfa_pkg::S_SPLIT_SH) |-> (cnt_q < bfa_pkg::CNT_W'(N)))
    else $error("split with a full table");

  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ohas_q |-> (ostat_q == bfa_pkg::ST_OK))
    else $error("returned pointer with error status");

  a_copy_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (ocopy_q != '0) |-> ohas_q)
    else $error("copy size without a returned pointer");

endmodule
`default_nettype wire

// File: tb/tb_best_fit_arena_allocator.sv
// Self-checking testbench for the best-fit arena allocator with a built-in segment table predictor.
`default_nettype none
module tb_best_fit_arena_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bfa_pkg::kind_e kind;
    logic [20:0]    req;
    logic           ptr_present;
    logic [20:0]    ptr;
  } request_t;

  typedef struct {
    bfa_pkg::status_e status;
    logic             present;
    logic [19:0]      payload;
    logic [19:0]      copy;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic [20:0] request_bytes_i = '0;
  logic pointer_present_i = 1'b0;
  logic [20:0] pointer_offset_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic result_present_o;
  logic [19:0] payload_offset_o;
  logic [19:0] copy_bytes_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [20:0] cfg_data_i = '0;

  best_fit_arena_allocator dut (.*);

  always #6 clk_i = ~clk_i;

  // Predicted segment table.
  int unsigned arena_reg;
  int unsigned seg_off [bfa_pkg::MAX_SEGMENTS];
  int unsigned seg_size [bfa_pkg::MAX_SEGMENTS];
  bit          seg_used [bfa_pkg::MAX_SEGMENTS];
  int unsigned seg_cnt;

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int issued_cnt = 0, accepted_cnt = 0, result_cnt = 0, error_cnt = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned stale_ptr = 64;
  bit in_taken = 1'b0;

  function automatic int unsigned arena_size();
    if (arena_reg < 64) return 64;
    if (arena_reg > 1048576) return 1048576;
    return arena_reg;
  endfunction

  function automatic void rebuild_table();
    seg_cnt = 1;
    seg_off[0] = 0;
    seg_size[0] = arena_size() - bfa_pkg::HEADER_BYTES;
    seg_used[0] = 1'b0;
  endfunction

  function automatic int unsigned round_up(int unsigned req);
    return ((req + bfa_pkg::ALIGN_BYTES - 1) / bfa_pkg::ALIGN_BYTES) * bfa_pkg::ALIGN_BYTES;
  endfunction

  function automatic void remove_seg(int unsigned i);
    for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
      seg_off[k] = seg_off[k+1];
      seg_size[k] = seg_size[k+1];
      seg_used[k] = seg_used[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic bfa_pkg::status_e carve(int unsigned req, output int unsigned pay);
    int unsigned need, best, min_size;
    bit found;
    pay = 0;
    best = 0;
    min_size = 32'hFFFF_FFFF;
    found = 1'b0;
    if (req == 0) return bfa_pkg::ST_NO_FIT;
    need = round_up(req);
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (!seg_used[i] && seg_size[i] >= need && seg_size[i] < min_size) begin
        best = i;
        min_size = seg_size[i];
        found = 1'b1;
      end
    end
    if (!found) return bfa_pkg::ST_NO_FIT;
    if (seg_size[best] >= need + bfa_pkg::HEADER_BYTES + bfa_pkg::ALIGN_BYTES &&
        seg_cnt < bfa_pkg::MAX_SEGMENTS) begin
      for (int unsigned k = seg_cnt; k > best + 1; k--) begin
        seg_off[k] = seg_off[k-1];
        seg_size[k] = seg_size[k-1];
        seg_used[k] = seg_used[k-1];
      end
      seg_off[best+1] = seg_off[best] + bfa_pkg::HEADER_BYTES + need;
      seg_size[best+1] = seg_size[best] - need - bfa_pkg::HEADER_BYTES;
      seg_used[best+1] = 1'b0;
      seg_size[best] = need;
      seg_cnt++;
    end
    seg_used[best] = 1'b1;
    pay = seg_off[best] + bfa_pkg::HEADER_BYTES;
    return bfa_pkg::ST_OK;
  endfunction

  function automatic int find_block(int unsigned ptr);
    int unsigned hdr;
    if (ptr < bfa_pkg::HEADER_BYTES) return -1;
    hdr = ptr - bfa_pkg::HEADER_BYTES;
    if (hdr >= arena_size()) return -1;
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (seg_off[i] == hdr && seg_used[i]) return int'(i);
    return -1;
  endfunction

  function automatic void release_seg(int unsigned i);
    seg_used[i] = 1'b0;
    if (i + 1 < seg_cnt && !seg_used[i+1]) begin
      seg_size[i] += seg_size[i+1] + bfa_pkg::HEADER_BYTES;
      remove_seg(i + 1);
    end
    if (i > 0 && !seg_used[i-1]) begin
      seg_size[i-1] += seg_size[i] + bfa_pkg::HEADER_BYTES;
      remove_seg(i);
    end
  endfunction

  function automatic bfa_pkg::status_e release_ptr(bit present, int unsigned ptr);
    int idx;
    if (!present) return bfa_pkg::ST_OK;
    idx = find_block(ptr);
    if (idx < 0) return bfa_pkg::ST_BAD_PTR;
    release_seg(idx);
    return bfa_pkg::ST_OK;
  endfunction

  function automatic answer_t serve_request(request_t w);
    answer_t a;
    int unsigned pay, need, old_size;
    int idx;
    a.status = bfa_pkg::ST_OK;
    a.present = 1'b0;
    a.copy = '0;
    pay = 0;
    case (w.kind)
      bfa_pkg::KIND_ALLOC: begin
        a.status = carve(w.req, pay);
        a.present = (a.status == bfa_pkg::ST_OK);
      end
      bfa_pkg::KIND_FREE: a.status = release_ptr(w.ptr_present, w.ptr);
      bfa_pkg::KIND_RESIZE: begin
        if (w.req == 0) begin
          a.status = (release_ptr(w.ptr_present, w.ptr) == bfa_pkg::ST_BAD_PTR) ?
                     bfa_pkg::ST_BAD_PTR : bfa_pkg::ST_NO_FIT;
        end else if (!w.ptr_present) begin
          a.status = carve(w.req, pay);
          a.present = (a.status == bfa_pkg::ST_OK);
        end else begin
          idx = find_block(w.ptr);
          if (idx < 0) begin
            a.status = bfa_pkg::ST_BAD_PTR;
          end else begin
            need = round_up(w.req);
            old_size = seg_size[idx];
            if (old_size >= need) begin
              pay = w.ptr;
              a.present = 1'b1;
            end else begin
              a.status = carve(need, pay);
              if (a.status == bfa_pkg::ST_OK) begin
                a.present = 1'b1;
                a.copy = old_size[19:0];
                idx = find_block(w.ptr);
                if (idx >= 0) release_seg(idx);
              end
            end
          end
        end
      end
      default: ;
    endcase
    a.payload = a.present ? pay[19:0] : 20'd0;
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_cnt, what, got, want);
    error_cnt++;
  endtask

  // Driver: words change on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          request_t w;
          w = pending_words.pop_front();
          kind_i <= w.kind;
          request_bytes_i <= w.req;
          pointer_present_i <= w.ptr_present;
          pointer_offset_i <= w.ptr;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: handshakes are sampled on the rising edge.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      request_t w;
      w.kind = bfa_pkg::kind_e'(kind_i);
      w.req = request_bytes_i;
      w.ptr_present = pointer_present_i;
      w.ptr = pointer_offset_i;
      expected_answers.push_back(serve_request(w));
      accepted_cnt++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_cnt++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (result_present_o !== e.present)
          report_mismatch("result_present", result_present_o, e.present);
        if (payload_offset_o !== e.payload)
          report_mismatch("payload_offset", payload_offset_o, e.payload);
        if (copy_bytes_o !== e.copy) report_mismatch("copy_bytes", copy_bytes_o, e.copy);
      end
      result_cnt++;
    end
  end

  task automatic send_word(bfa_pkg::kind_e kind, int unsigned req, bit present,
                           int unsigned ptr);
    request_t w;
    w.kind = kind;
    w.req = req[20:0];
    w.ptr_present = present;
    w.ptr = ptr[20:0];
    pending_words.push_back(w);
    issued_cnt++;
    // Later words are built from the table state this one leaves behind.
    wait (accepted_cnt == issued_cnt);
  endtask

  function automatic int unsigned live_ptr();
    int unsigned picks[$];
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (seg_used[i]) picks.push_back(seg_off[i] + bfa_pkg::HEADER_BYTES);
    if (picks.size() == 0) return stale_ptr;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(256, 1);
    if (r < 88) return $urandom_range(arena_size() / 4, 1);
    if (r < 93) return 0;
    return $urandom_range(21'h1F_FFFF);
  endfunction

  function automatic int unsigned pick_ptr(output bit present);
    int unsigned r;
    present = 1'b1;
    r = $urandom_range(99);
    if (r < 72) return live_ptr();
    if (r < 80) return stale_ptr;
    if (r < 86) return live_ptr() + bfa_pkg::ALIGN_BYTES * $urandom_range(4, 1);
    if (r < 90) return $urandom_range(bfa_pkg::HEADER_BYTES - 1);
    if (r < 95) return $urandom_range(21'h1F_FFFF);
    present = 1'b0;
    return $urandom_range(21'h1F_FFFF);
  endfunction

  task automatic random_words(int n);
    int unsigned r, ptr;
    bit present;
    repeat (n) begin
      r = $urandom_range(99);
      ptr = pick_ptr(present);
      // Lean toward freeing when the table is close to full.
      if (seg_cnt > 56 && r < 50) r = r + 50;
      if (r < 48) begin
        send_word(bfa_pkg::KIND_ALLOC, pick_size(), present, ptr);
      end else if (r < 78) begin
        if (present && find_block(ptr) >= 0) stale_ptr = ptr;
        send_word(bfa_pkg::KIND_FREE, pick_size(), present, ptr);
      end else if (r < 97) begin
        send_word(bfa_pkg::KIND_RESIZE, pick_size(), present, ptr);
      end else begin
        send_word(bfa_pkg::KIND_NONE, pick_size(), present, ptr);
      end
    end
  endtask

  task automatic settle();
    wait (pending_words.size() == 0 && accepted_cnt == issued_cnt &&
          expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_arena(int unsigned value);
    @(negedge clk_i);
    cfg_data_i <= value[20:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    arena_reg = value & 21'h1F_FFFF;
    rebuild_table();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned arenas [6];
    int unsigned lengths [6];
    int unsigned p, q;
    arenas = '{64, 1048576, 0, 2097151, 1536, 8192};
    lengths = '{60, 250, 40, 200, 250, 250};
    arena_reg = bfa_pkg::ARENA_RESET;
    rebuild_table();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening on the reset arena.
    send_word(bfa_pkg::KIND_ALLOC, 0, 1'b0, 0);
    send_word(bfa_pkg::KIND_ALLOC, 1, 1'b0, 0);
    p = expected_answers[$].payload;
    send_word(bfa_pkg::KIND_ALLOC, 17, 1'b0, 0);
    q = expected_answers[$].payload;
    send_word(bfa_pkg::KIND_ALLOC, 16, 1'b0, 0);
    send_word(bfa_pkg::KIND_FREE, 0, 1'b0, 0);
    send_word(bfa_pkg::KIND_NONE, 21'h1F_FFFF, 1'b1, 21'h1F_FFFF);
    send_word(bfa_pkg::KIND_RESIZE, 40, 1'b0, 0);
    send_word(bfa_pkg::KIND_RESIZE, 16, 1'b1, p);
    send_word(bfa_pkg::KIND_RESIZE, 100, 1'b1, p);
    send_word(bfa_pkg::KIND_RESIZE, 0, 1'b1, q);
    send_word(bfa_pkg::KIND_FREE, 0, 1'b1, q);
    send_word(bfa_pkg::KIND_FREE, 0, 1'b1, q + 16);
    send_word(bfa_pkg::KIND_FREE, 0, 1'b1, 0);
    send_word(bfa_pkg::KIND_FREE, 0, 1'b1, 21'h1F_FFFF);
    send_word(bfa_pkg::KIND_RESIZE, 0, 1'b1, 21'h1F_FFFF);
    send_word(bfa_pkg::KIND_RESIZE, 0, 1'b0, 0);
    send_word(bfa_pkg::KIND_ALLOC, 1048576, 1'b0, 0);
    send_word(bfa_pkg::KIND_ALLOC, 21'h1F_FFFF, 1'b0, 0);
    send_word(bfa_pkg::KIND_ALLOC, 65536 - 32 - 100, 1'b0, 0);
    send_word(bfa_pkg::KIND_RESIZE, 21'h1F_FFFF, 1'b1, live_ptr());
    random_words(230);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 33 : 47) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 47 : ((ph % 4 == 3) ? 33 : 0);
      write_arena(arenas[ph]);
      random_words(lengths[ph]);
    end

    settle();
    if (expected_answers.size() != 0) begin
      $display("%0d expected results never arrived", expected_answers.size());
      error_cnt++;
    end
    $display("Sent %0d requests over seven arena sizes, including both saturation limits.",
             issued_cnt);
    $display("Checked %0d results under four handshake pacing modes.", result_cnt);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
